[design/eri_pkg.sv]
// ----------------------------------------------------------------------------
// eri_pkg
// Shared types, constants and saturation helper for the rigid body integrator.
// ----------------------------------------------------------------------------
package eri_pkg;

  localparam int unsigned DataW    = 32;
  localparam int unsigned FracBits = 16;
  localparam int unsigned MassW    = 31;
  localparam int unsigned DtW      = 31;
  localparam int unsigned BounceW  = 17;
  localparam int unsigned BounceFracBits = 16;
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned NumLanes = 3;
  localparam int unsigned WideW    = 64;

  localparam logic signed [WideW-1:0] SatMax = WideW'(64'sd2147483647);
  localparam logic signed [WideW-1:0] SatMin = -WideW'(64'sd2147483648);

  localparam logic [MassW-1:0]   InvMassRst = MassW'(65536);
  localparam logic [BounceW-1:0] BounceRst  = BounceW'(65536);

  typedef enum logic [1:0] {
    OpAddForce = 2'd0,
    OpStep     = 2'd1,
    OpClamp    = 2'd2,
    OpSetPos   = 2'd3
  } op_e;

  typedef enum logic [CfgIdxW-1:0] {
    CfgInvMass = 3'd0,
    CfgAccelX  = 3'd1,
    CfgAccelY  = 3'd2,
    CfgAccelZ  = 3'd3,
    CfgGround  = 3'd4,
    CfgBounce  = 3'd5
  } cfg_idx_e;

  typedef struct packed {
    logic             accept;
    op_e              op;
    logic [DtW-1:0]   dt;
    logic             clamp_en;
  } lane_ctrl_t;

  typedef struct packed {
    logic signed [DataW-1:0] pos;
    logic signed [DataW-1:0] vel;
    logic signed [DataW-1:0] acc;
  } lane_state_t;

  function automatic logic signed [DataW-1:0] sat32(input logic signed [WideW-1:0] v);
    logic signed [DataW-1:0] r;
    if (v > SatMax) begin
      r = SatMax[DataW-1:0];
    end else if (v < SatMin) begin
      r = SatMin[DataW-1:0];
    end else begin
      r = v[DataW-1:0];
    end
    return r;
  endfunction

endpackage

[design/eri_if.sv]
// ----------------------------------------------------------------------------
// eri_if
// Request channels of the integrator: input items, results, config writes.
// ----------------------------------------------------------------------------
interface eri_in_if;
  logic                                valid;
  logic                                ready;
  logic [1:0]                          op;
  logic signed [eri_pkg::DataW-1:0]    vec_x;
  logic signed [eri_pkg::DataW-1:0]    vec_y;
  logic signed [eri_pkg::DataW-1:0]    vec_z;
  logic [eri_pkg::DtW-1:0]             time_step;

  modport source (output valid, op, vec_x, vec_y, vec_z, time_step, input ready);
  modport sink (input valid, op, vec_x, vec_y, vec_z, time_step, output ready);
endinterface

interface eri_out_if;
  logic                                valid;
  logic                                ready;
  logic signed [eri_pkg::DataW-1:0]    pos_out_x;
  logic signed [eri_pkg::DataW-1:0]    pos_out_y;
  logic signed [eri_pkg::DataW-1:0]    pos_out_z;
  logic signed [eri_pkg::DataW-1:0]    vel_out_x;
  logic signed [eri_pkg::DataW-1:0]    vel_out_y;
  logic signed [eri_pkg::DataW-1:0]    vel_out_z;
  logic signed [eri_pkg::DataW-1:0]    acc_out_x;
  logic signed [eri_pkg::DataW-1:0]    acc_out_y;
  logic signed [eri_pkg::DataW-1:0]    acc_out_z;

  modport source (output valid, pos_out_x, pos_out_y, pos_out_z, vel_out_x, vel_out_y,
                  vel_out_z, acc_out_x, acc_out_y, acc_out_z, input ready);
  modport sink (input valid, pos_out_x, pos_out_y, pos_out_z, vel_out_x, vel_out_y,
                vel_out_z, acc_out_x, acc_out_y, acc_out_z, output ready);
endinterface

interface eri_cfg_if;
  logic                                valid;
  logic                                ready;
  logic [eri_pkg::CfgIdxW-1:0]         index;
  logic [eri_pkg::DataW-1:0]           data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

[design/eri_lane.sv]
// ----------------------------------------------------------------------------
// eri_lane
// One axis: position, velocity, acceleration and force with Euler update.
// ----------------------------------------------------------------------------
module eri_lane (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  eri_pkg::lane_ctrl_t                   ctrl_i,
  input  logic signed [eri_pkg::DataW-1:0]      vec_i,
  input  logic [eri_pkg::MassW-1:0]             inv_mass_i,
  input  logic signed [eri_pkg::DataW-1:0]      fixed_acc_i,
  input  logic signed [eri_pkg::DataW-1:0]      ground_i,
  input  logic [eri_pkg::BounceW-1:0]           bounce_i,
  output eri_pkg::lane_state_t                  state_o
);

  localparam int unsigned VdtW = eri_pkg::DataW + eri_pkg::DtW;
  localparam int unsigned FimW = eri_pkg::DataW + eri_pkg::MassW;
  localparam int unsigned BprW = eri_pkg::DataW + eri_pkg::BounceW + 1;

  logic signed [eri_pkg::DataW-1:0] pos_q, pos_d, vel_q, vel_d;
  logic signed [eri_pkg::DataW-1:0] acc_q, acc_d, frc_q, frc_d;

  logic signed [VdtW-1:0]   vdt_prod, adt_prod;
  logic signed [FimW-1:0]   fim_prod;
  logic signed [BprW-1:0]   bnc_prod;
  logic signed [BprW:0]     bnc_neg;
  logic signed [eri_pkg::WideW-1:0] pos_sum, vel_sum, acc_sum, frc_sum;
  logic signed [eri_pkg::WideW-1:0] refl, bnc_vel;
  logic                     below;

  assign vdt_prod = vel_q * $signed({1'b0, ctrl_i.dt});
  assign adt_prod = acc_q * $signed({1'b0, ctrl_i.dt});
  assign fim_prod = frc_q * $signed({1'b0, inv_mass_i});
  assign bnc_prod = vel_q * $signed({1'b0, bounce_i});
  assign bnc_neg  = -((BprW+1)'(bnc_prod));

  assign pos_sum = eri_pkg::WideW'(pos_q) + eri_pkg::WideW'(vdt_prod >>> eri_pkg::FracBits);
  assign vel_sum = eri_pkg::WideW'(vel_q) + eri_pkg::WideW'(adt_prod >>> eri_pkg::FracBits);
  assign acc_sum = eri_pkg::WideW'(fim_prod >>> eri_pkg::FracBits)
                 + eri_pkg::WideW'(fixed_acc_i);
  assign frc_sum = eri_pkg::WideW'(frc_q) + eri_pkg::WideW'(vec_i);
  assign refl    = eri_pkg::WideW'(ground_i) + eri_pkg::WideW'(ground_i)
                 - eri_pkg::WideW'(pos_q);
  assign bnc_vel = eri_pkg::WideW'(bnc_neg >>> eri_pkg::BounceFracBits);
  assign below   = ctrl_i.clamp_en && (pos_q < ground_i);

  always_comb begin
    pos_d = pos_q;
    vel_d = vel_q;
    acc_d = acc_q;
    frc_d = frc_q;
    if (ctrl_i.accept) begin
      unique case (ctrl_i.op)
        eri_pkg::OpAddForce: begin
          frc_d = eri_pkg::sat32(frc_sum);
        end
        eri_pkg::OpStep: begin
          pos_d = eri_pkg::sat32(pos_sum);
          vel_d = eri_pkg::sat32(vel_sum);
          acc_d = eri_pkg::sat32(acc_sum);
          frc_d = '0;
        end
        eri_pkg::OpClamp: begin
          if (below) begin
            pos_d = eri_pkg::sat32(refl);
            vel_d = eri_pkg::sat32(bnc_vel);
          end
        end
        eri_pkg::OpSetPos: begin
          pos_d = vec_i;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q <= '0;
      vel_q <= '0;
      acc_q <= '0;
      frc_q <= '0;
    end else begin
      pos_q <= pos_d;
      vel_q <= vel_d;
      acc_q <= acc_d;
      frc_q <= frc_d;
    end
  end

  assign state_o.pos = pos_q;
  assign state_o.vel = vel_q;
  assign state_o.acc = acc_q;

endmodule

[design/eri_merge.sv]
// ----------------------------------------------------------------------------
// eri_merge
// Result stage: collects the lane states into one result request and
// runs the valid/ready flow for both channels.
// ----------------------------------------------------------------------------
module eri_merge (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  output logic                  accept_o,
  input  eri_pkg::lane_state_t  lanes_i [eri_pkg::NumLanes],
  eri_out_if.source             out_o
);

  logic valid_q, valid_d;

  assign in_ready_o = !valid_q || out_o.ready;
  assign accept_o   = in_valid_i && in_ready_o;
  assign valid_d    = accept_o || (valid_q && !out_o.ready);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  assign out_o.valid     = valid_q;
  assign out_o.pos_out_x = lanes_i[0].pos;
  assign out_o.pos_out_y = lanes_i[1].pos;
  assign out_o.pos_out_z = lanes_i[2].pos;
  assign out_o.vel_out_x = lanes_i[0].vel;
  assign out_o.vel_out_y = lanes_i[1].vel;
  assign out_o.vel_out_z = lanes_i[2].vel;
  assign out_o.acc_out_x = lanes_i[0].acc;
  assign out_o.acc_out_y = lanes_i[1].acc;
  assign out_o.acc_out_z = lanes_i[2].acc;

endmodule

[design/euler_rigid_body_integrator.sv]
// ----------------------------------------------------------------------------
// euler_rigid_body_integrator
// Explicit Euler integrator for one body in signed fixed point, three axis
// lanes working side by side, with force accumulation and ground bounce.
// ----------------------------------------------------------------------------
//   channel  dir  modport  payload
//   in_i     in   sink     op, vec_x/y/z, time_step
//   out_o    out  source   pos/vel/acc_out_x/y/z
//   cfg_i    in   sink     index, data (always ready)
//
// One request per cycle while results are taken; result in the next cycle.
// Each lane does its multiply-adds and saturation combinationally.
// The lane state registers hold the result; a new request is taken when the
// result is empty or taken in the same cycle. Reset clears the lane state.
// ----------------------------------------------------------------------------
module euler_rigid_body_integrator (
  input  logic      clk_i,
  input  logic      rst_ni,
  eri_in_if.sink    in_i,
  eri_out_if.source out_o,
  eri_cfg_if.sink   cfg_i
);

  logic [eri_pkg::MassW-1:0]          inv_mass_q;
  logic signed [eri_pkg::DataW-1:0]   fixed_acc_q [eri_pkg::NumLanes];
  logic signed [eri_pkg::DataW-1:0]   ground_q;
  logic [eri_pkg::BounceW-1:0]        bounce_q;

  logic                               accept;
  logic signed [eri_pkg::DataW-1:0]   vec [eri_pkg::NumLanes];
  eri_pkg::lane_ctrl_t                ctrl [eri_pkg::NumLanes];
  eri_pkg::lane_state_t               lanes [eri_pkg::NumLanes];

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      inv_mass_q     <= eri_pkg::InvMassRst;
      fixed_acc_q[0] <= '0;
      fixed_acc_q[1] <= '0;
      fixed_acc_q[2] <= '0;
      ground_q       <= '0;
      bounce_q       <= eri_pkg::BounceRst;
    end else if (cfg_i.valid) begin
      unique case (eri_pkg::cfg_idx_e'(cfg_i.index))
        eri_pkg::CfgInvMass: inv_mass_q     <= cfg_i.data[eri_pkg::MassW-1:0];
        eri_pkg::CfgAccelX:  fixed_acc_q[0] <= $signed(cfg_i.data);
        eri_pkg::CfgAccelY:  fixed_acc_q[1] <= $signed(cfg_i.data);
        eri_pkg::CfgAccelZ:  fixed_acc_q[2] <= $signed(cfg_i.data);
        eri_pkg::CfgGround:  ground_q       <= $signed(cfg_i.data);
        eri_pkg::CfgBounce:  bounce_q       <= cfg_i.data[eri_pkg::BounceW-1:0];
        default: begin
        end
      endcase
    end
  end

  assign vec[0] = in_i.vec_x;
  assign vec[1] = in_i.vec_y;
  assign vec[2] = in_i.vec_z;

  for (genvar g = 0; g < eri_pkg::NumLanes; g++) begin : g_lane
    assign ctrl[g].accept   = accept;
    assign ctrl[g].op       = eri_pkg::op_e'(in_i.op);
    assign ctrl[g].dt       = in_i.time_step;
    assign ctrl[g].clamp_en = (g == 1);

    eri_lane u_lane (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .ctrl_i      (ctrl[g]),
      .vec_i       (vec[g]),
      .inv_mass_i  (inv_mass_q),
      .fixed_acc_i (fixed_acc_q[g]),
      .ground_i    (ground_q),
      .bounce_i    (bounce_q),
      .state_o     (lanes[g])
    );
  end

  eri_merge u_merge (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_ready_o (in_i.ready),
    .accept_o   (accept),
    .lanes_i    (lanes),
    .out_o      (out_o)
  );

`ifndef SYNTHESIS
  a_accept_gives_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> out_o.valid)
    else $error("accepted request produced no result");

  a_set_pos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && in_i.op == eri_pkg::OpSetPos |=>
      out_o.pos_out_x == $past(in_i.vec_x) && out_o.pos_out_z == $past(in_i.vec_z))
    else $error("set position not applied");

  a_clamp_above: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && in_i.op == eri_pkg::OpClamp && !(out_o.pos_out_y < ground_q) |=>
      out_o.pos_out_y == $past(out_o.pos_out_y) &&
      out_o.vel_out_y == $past(out_o.vel_out_y))
    else $error("clamp changed a body above ground");

  a_state_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !accept |=> $stable(out_o.pos_out_x) && $stable(out_o.vel_out_y) &&
      $stable(out_o.acc_out_z))
    else $error("state changed without a request");
`endif

endmodule

[tb/eri_motion_checker.sv]
// ----------------------------------------------------------------------------
// eri_motion_checker
// Watches the request, result and register channels of the integrator, keeps
// its own copy of the body state and settings, and checks every result field
// against the state predicted for the matching request, oldest first.
// ----------------------------------------------------------------------------
module eri_motion_checker (
  input  logic clk_i,
  input  logic rst_ni,
  eri_in_if    in_mon,
  eri_out_if   out_mon,
  eri_cfg_if   cfg_mon,
  output int   fail_count_o,
  output int   pending_o,
  output int   checked_o,
  output int   bounce_count_o
);
  timeunit 1ns;
  timeprecision 1ps;

  import eri_pkg::*;

  localparam longint Max32 = 64'sd2147483647;
  localparam longint Min32 = -64'sd2147483648;

  typedef logic [8:0][DataW-1:0] snapshot_t;

  snapshot_t expected_q[$];

  logic signed [DataW-1:0] pos_s   [NumLanes];
  logic signed [DataW-1:0] vel_s   [NumLanes];
  logic signed [DataW-1:0] acc_s   [NumLanes];
  logic signed [DataW-1:0] frc_s   [NumLanes];
  logic signed [DataW-1:0] accel_s [NumLanes];
  logic signed [DataW-1:0] ground_s;
  logic [MassW-1:0]        inv_mass_s;
  logic [BounceW-1:0]      bounce_s;

  int errors  = 0;
  int checked = 0;
  int bounces = 0;

  string field_tag [9] = '{"pos_x", "pos_y", "pos_z", "vel_x", "vel_y", "vel_z",
                           "acc_x", "acc_y", "acc_z"};

  assign fail_count_o   = errors;
  assign checked_o      = checked;
  assign bounce_count_o = bounces;

  task automatic flag(input string msg);
    $display("[%0t] ERROR: %s", $realtime, msg);
    errors++;
  endtask

  function automatic logic signed [DataW-1:0] clip32(input longint v);
    if (v > Max32) return Max32[DataW-1:0];
    if (v < Min32) return Min32[DataW-1:0];
    return v[DataW-1:0];
  endfunction

  // exact product, floor to FracBits
  function automatic longint scale_floor(input logic signed [DataW-1:0] a,
                                         input logic [DataW-2:0] b);
    longint prod;
    prod = longint'(a) * longint'({1'b0, b});
    return prod >>> FracBits;
  endfunction

  function automatic void store_setting(input logic [CfgIdxW-1:0] idx,
                                        input logic [DataW-1:0] data);
    case (cfg_idx_e'(idx))
      CfgInvMass: inv_mass_s = data[MassW-1:0];
      CfgAccelX:  accel_s[0] = data;
      CfgAccelY:  accel_s[1] = data;
      CfgAccelZ:  accel_s[2] = data;
      CfgGround:  ground_s = data;
      CfgBounce:  bounce_s = data[BounceW-1:0];
      default: ;
    endcase
  endfunction

  function automatic snapshot_t advance_body(input logic [1:0] op,
                                             input logic signed [DataW-1:0] vx,
                                             input logic signed [DataW-1:0] vy,
                                             input logic signed [DataW-1:0] vz,
                                             input logic [DtW-1:0] dt);
    logic signed [DataW-1:0] vec [NumLanes];
    logic signed [DataW-1:0] vel_old;
    longint                  prod;
    snapshot_t               snap;
    vec[0] = vx;
    vec[1] = vy;
    vec[2] = vz;
    case (op_e'(op))
      OpAddForce: begin
        for (int i = 0; i < NumLanes; i++) begin
          frc_s[i] = clip32(longint'(frc_s[i]) + longint'(vec[i]));
        end
      end
      OpStep: begin
        for (int i = 0; i < NumLanes; i++) begin
          vel_old  = vel_s[i];
          pos_s[i] = clip32(longint'(pos_s[i]) + scale_floor(vel_old, dt));
          vel_s[i] = clip32(longint'(vel_old) + scale_floor(acc_s[i], dt));
          acc_s[i] = clip32(scale_floor(frc_s[i], inv_mass_s) + longint'(accel_s[i]));
          frc_s[i] = '0;
        end
      end
      OpClamp: begin
        if (pos_s[1] < ground_s) begin
          pos_s[1] = clip32(2 * longint'(ground_s) - longint'(pos_s[1]));
          prod     = -longint'(vel_s[1]) * longint'(bounce_s);
          vel_s[1] = clip32(prod >>> BounceFracBits);
          bounces++;
        end
      end
      default: begin
        for (int i = 0; i < NumLanes; i++) begin
          pos_s[i] = vec[i];
        end
      end
    endcase
    for (int i = 0; i < NumLanes; i++) begin
      snap[i]     = pos_s[i];
      snap[3 + i] = vel_s[i];
      snap[6 + i] = acc_s[i];
    end
    return snap;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    snapshot_t got;
    snapshot_t want;
    if (!rst_ni) begin
      expected_q.delete();
      inv_mass_s = InvMassRst;
      bounce_s   = BounceRst;
      ground_s   = '0;
      for (int i = 0; i < NumLanes; i++) begin
        pos_s[i]   = '0;
        vel_s[i]   = '0;
        acc_s[i]   = '0;
        frc_s[i]   = '0;
        accel_s[i] = '0;
      end
    end else begin
      if (cfg_mon.valid && cfg_mon.ready) begin
        store_setting(cfg_mon.index, cfg_mon.data);
      end
      if (in_mon.valid && in_mon.ready) begin
        expected_q.push_back(advance_body(in_mon.op, in_mon.vec_x, in_mon.vec_y,
                                          in_mon.vec_z, in_mon.time_step));
      end
      if (out_mon.valid && out_mon.ready) begin
        got[0] = out_mon.pos_out_x;
        got[1] = out_mon.pos_out_y;
        got[2] = out_mon.pos_out_z;
        got[3] = out_mon.vel_out_x;
        got[4] = out_mon.vel_out_y;
        got[5] = out_mon.vel_out_z;
        got[6] = out_mon.acc_out_x;
        got[7] = out_mon.acc_out_y;
        got[8] = out_mon.acc_out_z;
        if (expected_q.size() == 0) begin
          flag("result with no request outstanding");
        end else begin
          want = expected_q.pop_front();
          for (int k = 0; k < 9; k++) begin
            if (got[k] !== want[k]) begin
              flag($sformatf("result %0d, %s: got %h, want %h", checked, field_tag[k],
                             got[k], want[k]));
            end
          end
          checked++;
        end
      end
    end
    pending_o <= expected_q.size();
  end

endmodule

[tb/euler_rigid_body_integrator_tb.sv]
// ----------------------------------------------------------------------------
// euler_rigid_body_integrator_tb
// Drives the integrator with directed corner requests and then with random
// force/step/clamp frames under several register settings and handshake
// pressure levels; the checker beside the block predicts and compares.
// ----------------------------------------------------------------------------
module euler_rigid_body_integrator_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import eri_pkg::*;

  localparam int CycleLimit = 200000;
  localparam int NumPhases  = 8;
  localparam int PhaseReqs  = 185;
  localparam int HoldCycles = 300;

  logic clk_i;
  logic rst_ni;

  eri_in_if  in_ch ();
  eri_out_if out_ch ();
  eri_cfg_if cfg_ch ();

  int fail_count;
  int pending;
  int checked;
  int bounce_count;

  int gap_pct       = 0;
  int stall_pct     = 0;
  int cycle_count   = 0;
  int requests_sent = 0;
  int settings_used = 0;
  bit hold_start    = 1'b0;
  int hold_left     = 0;

  euler_rigid_body_integrator dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_ch),
    .out_o  (out_ch),
    .cfg_i  (cfg_ch)
  );

  eri_motion_checker motion_chk (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_mon         (in_ch),
    .out_mon        (out_ch),
    .cfg_mon        (cfg_ch),
    .fail_count_o   (fail_count),
    .pending_o      (pending),
    .checked_o      (checked),
    .bounce_count_o (bounce_count)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
  end

  initial begin
    while (cycle_count < CycleLimit) @(posedge clk_i);
    $display("timeout after %0d cycles", cycle_count);
    $display("euler_rigid_body_integrator regression: fail");
    $finish;
  end

  // result side: random stalls, plus one long hold-off on request
  initial begin
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_start) begin
        hold_start = 1'b0;
        hold_left  = HoldCycles;
      end
      if (hold_left > 0) begin
        out_ch.ready <= 1'b0;
        hold_left--;
      end else begin
        out_ch.ready <= ($urandom_range(99) >= stall_pct);
      end
    end
  end

  function automatic logic [DataW-1:0] rand_word();
    case ($urandom_range(9))
      0, 1, 2, 3, 4, 5: return DataW'(int'($urandom_range(1048576)) - 524288);
      6, 7: return $urandom();
      8: begin
        case ($urandom_range(3))
          0: return 32'h7FFF_FFFF;
          1: return 32'h8000_0000;
          2: return 32'h0000_0000;
          default: return 32'hFFFF_FFFF;
        endcase
      end
      default: return DataW'(int'($urandom_range(510)) - 255);
    endcase
  endfunction

  function automatic logic [DtW-1:0] rand_dt();
    case ($urandom_range(9))
      8: return DtW'($urandom_range(255));
      9: return DtW'($urandom());
      default: return DtW'($urandom_range(65536));
    endcase
  endfunction

  task automatic send_request(input op_e op, input logic [DataW-1:0] x,
                              input logic [DataW-1:0] y, input logic [DataW-1:0] z,
                              input logic [DtW-1:0] dt);
    while ($urandom_range(99) < gap_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_ch.valid     <= 1'b1;
    in_ch.op        <= op;
    in_ch.vec_x     <= x;
    in_ch.vec_y     <= y;
    in_ch.vec_z     <= z;
    in_ch.time_step <= dt;
    @(posedge clk_i);
    while (!in_ch.ready) @(posedge clk_i);
    requests_sent++;
  endtask

  task automatic write_register(input cfg_idx_e idx, input logic [DataW-1:0] data);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= data;
    @(posedge clk_i);
    while (!cfg_ch.ready) @(posedge clk_i);
  endtask

  task automatic apply_settings(input logic [DataW-1:0] mass, input logic [DataW-1:0] ax,
                                input logic [DataW-1:0] ay, input logic [DataW-1:0] az,
                                input logic [DataW-1:0] gnd, input logic [DataW-1:0] bnc);
    write_register(CfgInvMass, mass);
    write_register(CfgAccelX, ax);
    write_register(CfgAccelY, ay);
    write_register(CfgAccelZ, az);
    write_register(CfgGround, gnd);
    write_register(CfgBounce, bnc);
    cfg_ch.valid <= 1'b0;
    settings_used++;
  endtask

  // wait until every predicted result has been taken, then let the block settle
  task automatic drain();
    in_ch.valid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic run_traffic(input int n_req);
    int done_n;
    done_n = 0;
    while (done_n < n_req) begin
      if ($urandom_range(9) < 7) begin
        if ($urandom_range(1) == 1) begin
          send_request(OpAddForce, rand_word(), rand_word(), rand_word(), rand_dt());
          done_n++;
        end
        send_request(OpStep, rand_word(), rand_word(), rand_word(), rand_dt());
        send_request(OpClamp, rand_word(), rand_word(), rand_word(), rand_dt());
        done_n += 2;
      end else begin
        send_request(op_e'($urandom_range(3)), rand_word(), rand_word(), rand_word(),
                     rand_dt());
        done_n++;
      end
    end
  endtask

  task automatic directed_requests();
    send_request(OpAddForce, 32'h0001_0000, 32'h0002_0000, 32'hFFFD_0000, 31'd0);
    send_request(OpStep, 32'h0, 32'h0, 32'h0, 31'd65536);
    send_request(OpStep, 32'h0, 32'h0, 32'h0, 31'd32768);
    send_request(OpStep, 32'h0, 32'h0, 32'h0, 31'd65536);
    send_request(OpSetPos, 32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF, 31'd0);
    send_request(OpAddForce, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 31'd0);
    send_request(OpAddForce, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 31'd0);
    send_request(OpStep, 32'h0, 32'h0, 32'h0, 31'h7FFF_FFFF);
    send_request(OpStep, 32'h0, 32'h0, 32'h0, 31'h7FFF_FFFF);
    send_request(OpStep, 32'h0, 32'h0, 32'h0, 31'd0);
    // just below ground: the first clamp reflects
    send_request(OpSetPos, 32'h0, 32'hFFFF_FFFF, 32'h0, 31'd0);
    send_request(OpClamp, 32'h0, 32'h0, 32'h0, 31'd0);
    send_request(OpClamp, 32'h0, 32'h0, 32'h0, 31'd0);
    send_request(OpSetPos, 32'h0, 32'h8000_0000, 32'h0, 31'd0);
    send_request(OpClamp, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 31'h7FFF_FFFF);
    send_request(OpAddForce, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 31'd0);
    send_request(OpAddForce, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 31'd0);
    send_request(OpStep, 32'h0, 32'h0, 32'h0, 31'd1);
    send_request(OpStep, 32'h0, 32'h0, 32'h0, 31'd65536);
    send_request(OpSetPos, 32'h0, 32'hFFF0_0000, 32'h0, 31'd0);
    send_request(OpClamp, 32'h0, 32'h0, 32'h0, 31'd0);
    send_request(OpSetPos, 32'h0, 32'h0, 32'h0, 31'h7FFF_FFFF);
    send_request(OpStep, 32'h0, 32'h0, 32'h0, 31'd65536);
  endtask

  task automatic phase_settings(input int p);
    case (p)
      0: apply_settings(32'd65536, 32'h0, -32'sd642253, 32'h0, 32'h0, 32'd49152);
      // infinite mass, dead bounce
      1: apply_settings(32'h0, 32'd131072, -32'sd642253, -32'sd65536, -32'sd327680,
                        32'h0);
      2: apply_settings(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF,
                        32'h7FFF_FFFF, 32'h0001_FFFF);
      3: apply_settings(32'd32768, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000,
                        32'h8000_0000, 32'd65536);
      7: apply_settings($urandom(), $urandom(), $urandom(), $urandom(), $urandom(),
                        $urandom());
      default: apply_settings($urandom_range(262144), rand_word(), rand_word(),
                              rand_word(), rand_word(), $urandom_range(65536));
    endcase
  endtask

  initial begin
    rst_ni          = 1'b0;
    in_ch.valid     <= 1'b0;
    in_ch.op        <= OpAddForce;
    in_ch.vec_x     <= '0;
    in_ch.vec_y     <= '0;
    in_ch.vec_z     <= '0;
    in_ch.time_step <= '0;
    cfg_ch.valid    <= 1'b0;
    cfg_ch.index    <= CfgInvMass;
    cfg_ch.data     <= '0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    directed_requests();
    for (int p = 0; p < NumPhases; p++) begin
      drain();
      phase_settings(p);
      case (p % 4)
        1: begin gap_pct = 64; stall_pct = 0; end
        2: begin gap_pct = 0; stall_pct = 64; end
        3: begin gap_pct = 8; stall_pct = 8; end
        default: begin gap_pct = 0; stall_pct = 0; end
      endcase
      if (p == 4) begin
        hold_start = 1'b1;
      end
      run_traffic(PhaseReqs);
    end
    drain();
    repeat (8) @(posedge clk_i);

    $display("ran %0d requests under %0d register settings and 4 handshake mixes",
             requests_sent, settings_used);
    $display("%0d results compared, %0d ground bounces taken", checked, bounce_count);
    if (fail_count == 0 && pending == 0) begin
      $display("euler_rigid_body_integrator regression: pass");
    end else begin
      $display("euler_rigid_body_integrator regression: fail");
    end
    $finish;
  end

endmodule
